### rtl/assert_macros.svh
// Assertion macros shared by the ring buffer deque RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that prop holds at every rising edge of clk outside reset.
`define RDQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rdq assertion failed");

// Checks that cons holds at the edge after ante was seen, outside reset.
`define RDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdq assertion failed");

`else

`define RDQ_ASSERT(label, clk, rst, prop)
`define RDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/rdq_pkg.sv
// Types and constants for the ring buffer deque.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rdq_pkg;

  localparam int CAPACITY     = 16;
  localparam int ELEMENT_BITS = 32;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic shift_right;  // push at the front: every element moves one cell up
    logic shift_left;   // pop at the front: every element moves one cell down
    logic write_back;   // push at the back: the selected cell loads the value
  } cell_ctrl_t;

  typedef struct packed {
    logic              is_full;
    logic              is_empty;
    status_t           status;
    logic [DATA_W-1:0] read_value;
  } result_t;

endpackage

### rtl/rdq_cell.sv
// One storage cell of the deque row; holds a single element.
// Depends on rdq_pkg for the element width and the control struct.
`timescale 1ns / 1ps

module rdq_cell (
  input  logic                             clk,
  input  rdq_pkg::cell_ctrl_t              ctrl,
  input  logic                             sel,
  input  logic [rdq_pkg::ELEMENT_BITS-1:0] push_data,
  input  logic [rdq_pkg::ELEMENT_BITS-1:0] left_data,
  input  logic [rdq_pkg::ELEMENT_BITS-1:0] right_data,
  output logic [rdq_pkg::ELEMENT_BITS-1:0] data
);

  logic [rdq_pkg::ELEMENT_BITS-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.shift_right) begin
      data_next = left_data;
    end else if (ctrl.shift_left) begin
      data_next = right_data;
    end else if (ctrl.write_back && sel) begin
      data_next = push_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/rdq_out_reg.sv
// Result register between the deque row and the output stream.
// Depends on rdq_pkg for the result struct.
`timescale 1ns / 1ps

module rdq_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rdq_pkg::result_t load_data,
  output logic             load_ready,
  output logic             valid,
  input  logic             ready,
  output rdq_pkg::result_t data
);

  // A new word may enter when the register is empty or is being emptied now.
  assign load_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

### rtl/ring_buffer_deque_core.sv
// Double-ended queue: a row of storage cells plus fill counter and result register.
// Depends on rdq_pkg, rdq_cell, rdq_out_reg and assert_macros.svh.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request kind
//   (push front, push back, pop front, pop back, peek front, peek back) and
//   tdata the element to push. Every accepted word gives exactly one result
//   word on the m_axis channel with the element read, a status code and the
//   empty and full flags as they stand after the request.
//   The front element always sits in cell 0; the elements fill the row
//   upward, so the back element sits in the cell below the fill count.
//   A front push or pop moves the whole row by one cell at once; a back
//   push writes one cell, a back pop or peek reads one cell.
//   The result is registered and is valid in the cycle after acceptance.
//   One request is taken per cycle while the receiver takes results; the row
//   update and the count update both complete in the cycle of acceptance.
//   When the receiver stalls, the single result register holds its word and
//   s_axis_tready drops until that word is taken.
//   Reset empties the deque and the result register; the cells need no clear.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ring_buffer_deque_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] push_value
  input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] read_value, [33:32] status,
                                     // [34] is_empty, [35] is_full, rest zero
);

  localparam int CAP  = rdq_pkg::CAPACITY;
  localparam int EB   = rdq_pkg::ELEMENT_BITS;
  localparam int CW   = rdq_pkg::CNT_W;
  localparam int IW   = rdq_pkg::IDX_W;
  localparam int DW   = rdq_pkg::DATA_W;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      back_sum;
  logic [IW-1:0]      back_idx;
  logic               in_fire;
  logic               is_empty;
  logic               is_full;
  logic [EB-1:0]      push_data;
  logic [EB-1:0]      cells [CAP];
  logic [EB-1:0]      read_elem;
  rdq_pkg::cell_ctrl_t ctrl;
  rdq_pkg::result_t   result;
  rdq_pkg::result_t   out_data;
  rdq_pkg::req_t      req;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(CAP));
  assign push_data = EB'(s_axis_tdata);
  assign req       = rdq_pkg::req_t'(s_axis_tuser);
  assign back_sum  = count - CW'(1);
  assign back_idx  = back_sum[IW-1:0];

  // Decode the request into row control, count update and result word.
  always_comb begin
    ctrl              = '0;
    count_next        = count;
    read_elem         = '0;
    result.status     = rdq_pkg::ST_OK;
    case (req)
      rdq_pkg::REQ_PUSH_FRONT: begin
        if (is_full) begin
          result.status = rdq_pkg::ST_FULL;
        end else begin
          ctrl.shift_right = in_fire;
          count_next       = count + CW'(1);
        end
      end
      rdq_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          result.status = rdq_pkg::ST_FULL;
        end else begin
          ctrl.write_back = in_fire;
          count_next      = count + CW'(1);
        end
      end
      rdq_pkg::REQ_POP_FRONT: begin
        if (is_empty) begin
          result.status = rdq_pkg::ST_EMPTY;
        end else begin
          read_elem       = cells[0];
          ctrl.shift_left = in_fire;
          count_next      = count - CW'(1);
        end
      end
      rdq_pkg::REQ_POP_BACK: begin
        if (is_empty) begin
          result.status = rdq_pkg::ST_EMPTY;
        end else begin
          read_elem  = cells[back_idx];
          count_next = count - CW'(1);
        end
      end
      rdq_pkg::REQ_PEEK_FRONT: begin
        if (is_empty) begin
          result.status = rdq_pkg::ST_EMPTY;
        end else begin
          read_elem = cells[0];
        end
      end
      rdq_pkg::REQ_PEEK_BACK: begin
        if (is_empty) begin
          result.status = rdq_pkg::ST_EMPTY;
        end else begin
          read_elem = cells[back_idx];
        end
      end
      default: begin
      end
    endcase
    result.read_value = DW'(read_elem);
    result.is_empty   = (count_next == '0);
    result.is_full    = (count_next == CW'(CAP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // The cell row: cell 0 takes the pushed word on a front push, and the top
  // cell takes zeros on a front pop since nothing lies above it.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [EB-1:0] left_in;
    logic [EB-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = push_data;
    end else begin : g_inner_l
      assign left_in = cells[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cells[i+1];
    end

    rdq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sel        (count == CW'(i)),
      .push_data  (push_data),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cells[i])
    );
  end

  rdq_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire),
    .load_data  (result),
    .load_ready (s_axis_tready),
    .valid      (m_axis_tvalid),
    .ready      (m_axis_tready),
    .data       (out_data)
  );

  assign m_axis_tdata = {4'b0000, out_data.is_full, out_data.is_empty,
                         out_data.status, out_data.read_value};

  `RDQ_ASSERT(a_count_range, clk, rst, count <= CW'(CAP))
  `RDQ_ASSERT_NEXT(a_result_follows, clk, rst, in_fire, m_axis_tvalid)
  `RDQ_ASSERT_NEXT(a_push_back_grows, clk, rst,
                   in_fire && req == rdq_pkg::REQ_PUSH_BACK && !is_full,
                   count == $past(count) + CW'(1))
  `RDQ_ASSERT_NEXT(a_empty_flag, clk, rst, in_fire,
                   out_data.is_empty == (count == '0))
  `RDQ_ASSERT_NEXT(a_refused_keeps_count, clk, rst,
                   in_fire && result.status != rdq_pkg::ST_OK,
                   count == $past(count))

endmodule

### test/tb_ring_buffer_deque_core.sv
// Self-checking testbench for ring_buffer_deque_core: random request words against a deque predictor.
// Depends on rdq_pkg and the ring_buffer_deque_core RTL; no files or arguments are read.
`timescale 1ns / 1ps

module tb_ring_buffer_deque_core;

  // The request field is three bits wide; these two codes are not operations.
  localparam logic [rdq_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [rdq_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

  localparam int          RANDOM_REQUESTS = 600;
  localparam int          HOLD_AT_RESULT  = 200;
  localparam int          HOLD_CYCLES     = 120;
  localparam int          DRAIN_CYCLES    = 10;
  localparam int unsigned IDLE_LIMIT      = 2000;

  localparam logic [rdq_pkg::DATA_W-1:0] ELEM_MASK =
    (rdq_pkg::ELEMENT_BITS >= rdq_pkg::DATA_W) ? {rdq_pkg::DATA_W{1'b1}} :
    rdq_pkg::DATA_W'((64'd1 << rdq_pkg::ELEMENT_BITS) - 64'd1);

  typedef struct {
    logic [rdq_pkg::REQ_W-1:0]  kind;
    logic [rdq_pkg::DATA_W-1:0] value;
    int unsigned                gap;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [31:0] push_value
  logic [2:0]  s_axis_tuser  = '0;  // [2:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] read_value, [33:32] status,
                                    // [34] is_empty, [35] is_full, rest zero

  request_t                   pending_requests[$];
  rdq_pkg::result_t           expected_results[$];
  logic [rdq_pkg::DATA_W-1:0] held_elements[$];

  request_t    staged;
  logic        have_staged = 1'b0;
  int unsigned gap_left;
  int          failures = 0;
  int          results_seen = 0;
  int unsigned idle_cycles = 0;

  int unsigned stall_left;
  int unsigned calm_left;
  int unsigned hold_left;
  logic        hold_done = 1'b0;

  ring_buffer_deque_core u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Applies one accepted request to the predicted deque contents.
  task automatic predict_deque_result(input logic [rdq_pkg::REQ_W-1:0] kind,
                                      input logic [rdq_pkg::DATA_W-1:0] value);
    rdq_pkg::result_t res;
    logic             was_empty;
    logic             was_full;
    was_empty      = (held_elements.size() == 0);
    was_full       = (held_elements.size() >= rdq_pkg::CAPACITY);
    res.read_value = '0;
    res.status     = rdq_pkg::ST_OK;
    case (kind)
      rdq_pkg::REQ_PUSH_FRONT: begin
        if (was_full) res.status = rdq_pkg::ST_FULL;
        else held_elements.push_front(value & ELEM_MASK);
      end
      rdq_pkg::REQ_PUSH_BACK: begin
        if (was_full) res.status = rdq_pkg::ST_FULL;
        else held_elements.push_back(value & ELEM_MASK);
      end
      rdq_pkg::REQ_POP_FRONT: begin
        if (was_empty) res.status = rdq_pkg::ST_EMPTY;
        else res.read_value = held_elements.pop_front();
      end
      rdq_pkg::REQ_POP_BACK: begin
        if (was_empty) res.status = rdq_pkg::ST_EMPTY;
        else res.read_value = held_elements.pop_back();
      end
      rdq_pkg::REQ_PEEK_FRONT: begin
        if (was_empty) res.status = rdq_pkg::ST_EMPTY;
        else res.read_value = held_elements[0];
      end
      rdq_pkg::REQ_PEEK_BACK: begin
        if (was_empty) res.status = rdq_pkg::ST_EMPTY;
        else res.read_value = held_elements[held_elements.size() - 1];
      end
      default: ;
    endcase
    res.is_empty = (held_elements.size() == 0);
    res.is_full  = (held_elements.size() >= rdq_pkg::CAPACITY);
    expected_results.push_back(res);
  endtask

  function automatic void add_request(logic [rdq_pkg::REQ_W-1:0] kind,
                                      logic [rdq_pkg::DATA_W-1:0] value,
                                      int unsigned gap);
    request_t req;
    req.kind  = kind;
    req.value = value;
    req.gap   = gap;
    pending_requests.push_back(req);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [rdq_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // Mode 0 leans toward pushes so the deque fills, mode 1 toward pops so it drains.
  function automatic logic [rdq_pkg::REQ_W-1:0] pick_kind(int mode);
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    push_pct = (mode == 0) ? 65 : (mode == 1) ? 15 : 38;
    pop_pct  = (mode == 0) ? 15 : (mode == 1) ? 65 : 38;
    r = $urandom_range(99);
    if (r < 3) return (r == 0) ? REQ_SPARE_A : REQ_SPARE_B;
    if (r < 3 + push_pct)
      return $urandom_range(1) ? rdq_pkg::REQ_PUSH_FRONT : rdq_pkg::REQ_PUSH_BACK;
    if (r < 3 + push_pct + pop_pct)
      return $urandom_range(1) ? rdq_pkg::REQ_POP_FRONT : rdq_pkg::REQ_POP_BACK;
    return $urandom_range(1) ? rdq_pkg::REQ_PEEK_FRONT : rdq_pkg::REQ_PEEK_BACK;
  endfunction

  // Sender: holds each word until it is taken, with random gaps between words.
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_deque_result(s_axis_tuser, s_axis_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (!have_staged && pending_requests.size() > 0) begin
          staged      = pending_requests.pop_front();
          have_staged = 1'b1;
          gap_left    = staged.gap;
        end
        if (have_staged) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            s_axis_tdata <= staged.value;
            s_axis_tuser <= staged.kind;
            nxt_valid   = 1'b1;
            have_staged = 1'b0;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // Receiver: checks each result word and stalls at random, once for a long stretch.
  always @(posedge clk) begin
    rdq_pkg::result_t exp_res;
    logic             rdy;
    int unsigned      r;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          failures++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.read_value) begin
            $error("read_value: expected %h, got %h", exp_res.read_value, m_axis_tdata[31:0]);
            failures++;
          end
          if (m_axis_tdata[33:32] !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, m_axis_tdata[33:32]);
            failures++;
          end
          if (m_axis_tdata[34] !== exp_res.is_empty) begin
            $error("is_empty: expected %b, got %b", exp_res.is_empty, m_axis_tdata[34]);
            failures++;
          end
          if (m_axis_tdata[35] !== exp_res.is_full) begin
            $error("is_full: expected %b, got %b", exp_res.is_full, m_axis_tdata[35]);
            failures++;
          end
          if (m_axis_tdata[39:36] !== 4'd0) begin
            $error("padding: expected 0, got %h", m_axis_tdata[39:36]);
            failures++;
          end
        end
      end
      if (results_seen == HOLD_AT_RESULT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(99);
          if (r < 12) stall_left = $urandom_range(1, 3);
          else if (r < 15) stall_left = $urandom_range(8, 30);
          else if (r >= 97) calm_left = $urandom_range(30, 80);
        end
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ring_buffer_deque_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int count;
    int mode;
    int burst;
    bit calm;
    logic [rdq_pkg::REQ_W-1:0] kind;

    // Refusals on the empty deque.
    add_request(rdq_pkg::REQ_PEEK_FRONT, 32'hFFFF_FFFF, 0);
    add_request(rdq_pkg::REQ_PEEK_BACK, 32'h0, 0);
    add_request(rdq_pkg::REQ_POP_FRONT, 32'hFFFF_FFFF, 0);
    add_request(rdq_pkg::REQ_POP_BACK, 32'h0, 0);
    // Fill from both ends with extreme and random values, refuse pushes while full, then peek and pop both ends.
    for (int i = 0; i < rdq_pkg::CAPACITY; i++) begin
      if (i == 0) add_request(rdq_pkg::REQ_PUSH_BACK, 32'h0, 0);
      else if (i == 1) add_request(rdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 0);
      else add_request(i[0] ? rdq_pkg::REQ_PUSH_FRONT : rdq_pkg::REQ_PUSH_BACK, $urandom, 0);
    end
    add_request(rdq_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5, 0);
    add_request(rdq_pkg::REQ_PUSH_BACK, 32'h5A5A_5A5A, 0);
    add_request(rdq_pkg::REQ_PEEK_FRONT, 32'h0, 0);
    add_request(rdq_pkg::REQ_PEEK_BACK, 32'h0, 0);
    add_request(rdq_pkg::REQ_POP_FRONT, 32'h0, 0);
    add_request(rdq_pkg::REQ_POP_BACK, 32'h0, 0);
    // Codes outside the operation set must leave the contents alone.
    add_request(REQ_SPARE_A, 32'hFFFF_FFFF, 0);
    add_request(REQ_SPARE_B, 32'hFFFF_FFFF, 0);

    count = 0;
    while (count < RANDOM_REQUESTS) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(20, 60);
      calm  = ($urandom_range(3) == 0);
      for (int i = 0; i < burst; i++) begin
        kind = pick_kind(mode);
        add_request(kind, pick_value(), calm ? 0 : pick_gap());
        if (kind != REQ_SPARE_A && kind != REQ_SPARE_B) count++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || have_staged || s_axis_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("ring_buffer_deque_core test passed");
    end else begin
      $display("ring_buffer_deque_core test failed");
    end
    $finish;
  end

endmodule
